### rtl/core/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: field widths and fixed-point constants.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int unsigned CHANNEL_BITS_DEF = 8;

  localparam int unsigned HUE_BITS = 15;
  localparam int unsigned SAT_BITS = 16;
  localparam int unsigned BRI_BITS = 8;
  localparam int unsigned OUT_DATA_BITS = ((HUE_BITS + SAT_BITS + BRI_BITS + 7) / 8) * 8;

  localparam int unsigned QUO_BITS  = 16;
  localparam int unsigned HUE_SIXTH = 3840;
  localparam int unsigned HUE_FULL  = 23040;
  localparam int unsigned SAT_ONE   = 65535;

  localparam int unsigned GREEN_OFS = 2;
  localparam int unsigned BLUE_OFS  = 4;
  localparam int unsigned TURN_OFS  = 6;

endpackage

### rtl/core/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: front end, divider cell chain, hue wrap
// and output register. Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div_cell.
//
//   port group  role    payload (tdata, low bit first)
//   in_*        slave   red, green, blue (CHANNEL_BITS each), zero fill
//   out_*       master  hue[14:0], saturation[30:15], brightness[38:31], zero fill
//
// One pixel per clock while the output is not stalled; stages: two front stages, one divider cell
// per quotient bit (16), and the output register.
// rst_n (synchronous) clears every valid bit; payload registers are not reset.
// The whole pipeline advances when the output register is empty or being taken;
// in_tready follows that advance.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit import rgbhsv_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     in_tdata,  // red, green, blue
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [OUT_DATA_BITS-1:0]                out_tdata  // hue, saturation, brightness
);

  localparam int unsigned W = CHANNEL_BITS;

  logic ce;

  logic [W-1:0]        c_sat_rem [QUO_BITS+1];
  logic [QUO_BITS-1:0] c_sat_sh  [QUO_BITS+1];
  logic [W-1:0]        c_sat_div [QUO_BITS+1];
  logic [W-1:0]        c_hue_rem [QUO_BITS+1];
  logic [QUO_BITS-1:0] c_hue_sh  [QUO_BITS+1];
  logic [W-1:0]        c_hue_div [QUO_BITS+1];
  logic                c_zero    [QUO_BITS+1];
  logic                c_vld     [QUO_BITS+1];

  logic [QUO_BITS-1:0] hue_q, hue_wrap;
  logic [HUE_BITS-1:0] hue_fin;
  logic [SAT_BITS-1:0] sat_fin;
  logic [BRI_BITS-1:0] bri_fin;

  logic                     out_vld_r, out_vld_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  assign ce        = !out_vld_r || out_tready;
  assign in_tready = ce;

  rgbhsv_front #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (in_tvalid),
    .red     (in_tdata[W-1:0]),
    .green   (in_tdata[2*W-1:W]),
    .blue    (in_tdata[3*W-1:2*W]),
    .out_vld (c_vld[0]),
    .sat_rem (c_sat_rem[0]),
    .sat_sh  (c_sat_sh[0]),
    .sat_div (c_sat_div[0]),
    .hue_rem (c_hue_rem[0]),
    .hue_sh  (c_hue_sh[0]),
    .hue_div (c_hue_div[0]),
    .zero    (c_zero[0])
  );

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    rgbhsv_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ce          (ce),
      .in_vld      (c_vld[i]),
      .in_sat_rem  (c_sat_rem[i]),
      .in_sat_sh   (c_sat_sh[i]),
      .in_sat_div  (c_sat_div[i]),
      .in_hue_rem  (c_hue_rem[i]),
      .in_hue_sh   (c_hue_sh[i]),
      .in_hue_div  (c_hue_div[i]),
      .in_zero     (c_zero[i]),
      .out_vld     (c_vld[i+1]),
      .out_sat_rem (c_sat_rem[i+1]),
      .out_sat_sh  (c_sat_sh[i+1]),
      .out_sat_div (c_sat_div[i+1]),
      .out_hue_rem (c_hue_rem[i+1]),
      .out_hue_sh  (c_hue_sh[i+1]),
      .out_hue_div (c_hue_div[i+1]),
      .out_zero    (c_zero[i+1])
    );
  end

  // wrap the hue into one turn; equal channels force hue and saturation to zero
  always_comb begin
    hue_q    = c_hue_sh[QUO_BITS];
    hue_wrap = (hue_q >= QUO_BITS'(HUE_FULL)) ? hue_q - QUO_BITS'(HUE_FULL) : hue_q;
    hue_fin  = c_zero[QUO_BITS] ? '0 : hue_wrap[HUE_BITS-1:0];
    sat_fin  = c_zero[QUO_BITS] ? '0 : SAT_BITS'(c_sat_sh[QUO_BITS]);
    bri_fin  = BRI_BITS'(c_sat_div[QUO_BITS]);
  end

  assign out_vld_nxt = ce ? c_vld[QUO_BITS] : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= OUT_DATA_BITS'({bri_fin, sat_fin, hue_fin});
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/rgbhsv_front.sv
// Front end of the RGB to HSV converter: max/min/delta, hue numerator and the
// two scaled dividends, over two register stages. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_front import rgbhsv_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    out_vld,
  output logic [CHANNEL_BITS-1:0] sat_rem,
  output logic [QUO_BITS-1:0]     sat_sh,
  output logic [CHANNEL_BITS-1:0] sat_div,
  output logic [CHANNEL_BITS-1:0] hue_rem,
  output logic [QUO_BITS-1:0]     hue_sh,
  output logic [CHANNEL_BITS-1:0] hue_div,
  output logic                    zero
);

  localparam int unsigned W  = CHANNEL_BITS;
  localparam int unsigned SW = W + 4;
  localparam int unsigned PW = W + QUO_BITS;

  logic [W-1:0]  mx_rg, mn_rg, mx, mn, delta;
  logic [SW-1:0] sixths;

  logic          vld_a_r, vld_a_nxt;
  logic [W-1:0]  mx_a_r, delta_a_r;
  logic [SW-1:0] sixths_a_r;

  logic [PW-1:0] sat_prod, hue_prod;

  logic          vld_b_r, vld_b_nxt;
  logic [PW-1:0] sat_prod_r, hue_prod_r;
  logic [W-1:0]  mx_b_r, delta_b_r;

  always_comb begin
    mx_rg = (red > green) ? red : green;
    mn_rg = (red < green) ? red : green;
    mx    = (mx_rg > blue) ? mx_rg : blue;
    mn    = (mn_rg < blue) ? mn_rg : blue;
    delta = mx - mn;
    if (red >= mx) begin
      sixths = SW'(TURN_OFS) * SW'(delta) + SW'(green) - SW'(blue);
    end else if (green >= mx) begin
      sixths = SW'(TURN_OFS + GREEN_OFS) * SW'(delta) + SW'(blue) - SW'(red);
    end else begin
      sixths = SW'(TURN_OFS + BLUE_OFS) * SW'(delta) + SW'(red) - SW'(green);
    end
  end

  assign vld_a_nxt = ce ? in_vld : vld_a_r;
  assign vld_b_nxt = ce ? vld_a_r : vld_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_a_nxt;
      vld_b_r <= vld_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mx_a_r     <= mx;
      delta_a_r  <= delta;
      sixths_a_r <= sixths;
    end
  end

  assign sat_prod = PW'(delta_a_r) * PW'(SAT_ONE);
  assign hue_prod = PW'(sixths_a_r) * PW'(HUE_SIXTH);

  always_ff @(posedge clk) begin
    if (ce) begin
      sat_prod_r <= sat_prod;
      hue_prod_r <= hue_prod;
      mx_b_r     <= mx_a_r;
      delta_b_r  <= delta_a_r;
    end
  end

  assign out_vld = vld_b_r;
  assign sat_rem = sat_prod_r[PW-1:QUO_BITS];
  assign sat_sh  = sat_prod_r[QUO_BITS-1:0];
  assign sat_div = mx_b_r;
  assign hue_rem = hue_prod_r[PW-1:QUO_BITS];
  assign hue_sh  = hue_prod_r[QUO_BITS-1:0];
  assign hue_div = delta_b_r;
  assign zero    = (delta_b_r == '0);

endmodule

### rtl/core/rgbhsv_div_cell.sv
// One cell of the divider chain: a restoring step for saturation and hue each,
// plus the pixel payload handed to the next cell. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

module rgbhsv_div_cell import rgbhsv_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  logic [CHANNEL_BITS-1:0] in_sat_rem,
  input  logic [QUO_BITS-1:0]     in_sat_sh,
  input  logic [CHANNEL_BITS-1:0] in_sat_div,
  input  logic [CHANNEL_BITS-1:0] in_hue_rem,
  input  logic [QUO_BITS-1:0]     in_hue_sh,
  input  logic [CHANNEL_BITS-1:0] in_hue_div,
  input  logic                    in_zero,
  output logic                    out_vld,
  output logic [CHANNEL_BITS-1:0] out_sat_rem,
  output logic [QUO_BITS-1:0]     out_sat_sh,
  output logic [CHANNEL_BITS-1:0] out_sat_div,
  output logic [CHANNEL_BITS-1:0] out_hue_rem,
  output logic [QUO_BITS-1:0]     out_hue_sh,
  output logic [CHANNEL_BITS-1:0] out_hue_div,
  output logic                    out_zero
);

  localparam int unsigned W = CHANNEL_BITS;

  logic [W:0]   sat_ext, hue_ext;
  logic [W+1:0] sat_diff, hue_diff;
  logic         sat_borrow, hue_borrow;

  logic          vld_r, vld_nxt;
  logic [W-1:0]  sat_rem_r, sat_rem_nxt, hue_rem_r, hue_rem_nxt;
  logic [QUO_BITS-1:0] sat_sh_r, sat_sh_nxt, hue_sh_r, hue_sh_nxt;
  logic [W-1:0]  sat_div_r, hue_div_r;
  logic          zero_r;

  always_comb begin
    sat_ext    = {in_sat_rem, in_sat_sh[QUO_BITS-1]};
    sat_diff   = {1'b0, sat_ext} - {2'b00, in_sat_div};
    sat_borrow = sat_diff[W+1];
    sat_rem_nxt = sat_borrow ? sat_ext[W-1:0] : sat_diff[W-1:0];
    sat_sh_nxt  = {in_sat_sh[QUO_BITS-2:0], ~sat_borrow};

    hue_ext    = {in_hue_rem, in_hue_sh[QUO_BITS-1]};
    hue_diff   = {1'b0, hue_ext} - {2'b00, in_hue_div};
    hue_borrow = hue_diff[W+1];
    hue_rem_nxt = hue_borrow ? hue_ext[W-1:0] : hue_diff[W-1:0];
    hue_sh_nxt  = {in_hue_sh[QUO_BITS-2:0], ~hue_borrow};
  end

  assign vld_nxt = ce ? in_vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sat_rem_r <= sat_rem_nxt;
      sat_sh_r  <= sat_sh_nxt;
      sat_div_r <= in_sat_div;
      hue_rem_r <= hue_rem_nxt;
      hue_sh_r  <= hue_sh_nxt;
      hue_div_r <= in_hue_div;
      zero_r    <= in_zero;
    end
  end

  assign out_vld     = vld_r;
  assign out_sat_rem = sat_rem_r;
  assign out_sat_sh  = sat_sh_r;
  assign out_sat_div = sat_div_r;
  assign out_hue_rem = hue_rem_r;
  assign out_hue_sh  = hue_sh_r;
  assign out_hue_div = hue_div_r;
  assign out_zero    = zero_r;

endmodule
